@@ hdl/assert_macros.svh @@
// Assertion macros shared by the compensation RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked during reset too
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bptc_pkg.sv @@
// Shared types and constants for the barometric compensation block
package bptc_pkg;

  localparam int WORD_W = 64;
  localparam int CNT_W  = $clog2(WORD_W);
  localparam int CAL_W  = 48;
  localparam int RAW_W  = 20;

  typedef enum logic [1:0] {
    CFG_TEMP     = 2'd0,
    CFG_PRESS_LO = 2'd1,
    CFG_PRESS_MI = 2'd2,
    CFG_PRESS_HI = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_A,
    ST_T_D,
    ST_T_E,
    ST_P_1,
    ST_P_2,
    ST_P_3,
    ST_P_4,
    ST_P_5,
    ST_P_6,
    ST_P_7,
    ST_P_DIV,
    ST_P_8,
    ST_P_9,
    ST_P_10,
    ST_FIN
  } state_t;

endpackage

@@ hdl/bptc_mul.sv @@
// Bit-serial shift-add multiplier, low word of the product
`include "assert_macros.svh"
module bptc_mul
  import bptc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic              done,
  output logic [WORD_W-1:0] prod
);

  logic [WORD_W-1:0] mcand;
  logic [WORD_W-1:0] mplier;
  logic [WORD_W-1:0] acc;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;

  `ASSERT_CLK(a_mul_done_idle, done |-> !busy, "multiplier done while still stepping")
  `ASSERT_CLK(a_mul_start_busy, start |=> busy, "multiplier did not start")

endmodule

@@ hdl/bptc_div.sv @@
// Bit-serial restoring divider, unsigned quotient
`include "assert_macros.svh"
module bptc_div
  import bptc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic              done,
  output logic [WORD_W-1:0] quo
);

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] qsr;
  logic [WORD_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [WORD_W:0]   trial_in;
  logic [WORD_W:0]   trial;

  assign trial_in = {rem, qsr[WORD_W-1]};
  assign trial    = trial_in - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qsr <= num;
      dsr <= den;
    end else if (busy) begin
      if (trial[WORD_W]) begin
        rem <= trial_in[WORD_W-1:0];
        qsr <= {qsr[WORD_W-2:0], 1'b0};
      end else begin
        rem <= trial[WORD_W-1:0];
        qsr <= {qsr[WORD_W-2:0], 1'b1};
      end
    end
  end

  assign quo = qsr;

  `ASSERT_CLK(a_div_done_idle, done |-> !busy, "divider done while still stepping")

endmodule

@@ hdl/baro_temp_pressure_compensation_top.sv @@
// Top level: barometric temperature / pressure compensation sequencer
// Use: write the four 48-bit calibration registers on the cfg channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data; always ready) while idle.
// Send items on in_valid/in_ready: req_type 0 is a raw temperature, 1 a raw
// pressure. Each item gives exactly one result on out_valid/out_ready.
// A temperature item also updates the stored fine temperature used by
// later pressure items.
// All arithmetic goes through one bit-serial multiplier and one bit-serial
// divider, one bit per cycle over 64 bits. A temperature item takes three
// products, a pressure item ten products and one quotient, fewer when the
// pressure divisor is zero. One item is in flight at a time.
// in_ready is high while the sequencer is idle, even if a result still
// waits in the output register; a stalled receiver holds the finished
// item in the last step until the output register frees.
// Reset clears the calibration registers, the fine temperature and all
// control state; no result is pending afterwards.
`include "assert_macros.svh"
module baro_temp_pressure_compensation_top
  import bptc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [CAL_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic [RAW_W-1:0]        raw_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    result_kind,
  output logic signed [31:0]      temperature_centi,
  output logic [31:0]             pressure_q24_8,
  output logic                    pressure_invalid
);

  function automatic logic [WORD_W-1:0] sx16(input logic [15:0] v);
    return {{(WORD_W-16){v[15]}}, v};
  endfunction

  function automatic logic [WORD_W-1:0] sx32(input logic [31:0] v);
    return {{(WORD_W-32){v[31]}}, v};
  endfunction

  logic [CAL_W-1:0]  cal_t, cal_pl, cal_pm, cal_ph;
  logic [31:0]       fine_t;
  state_t            state, state_next;
  logic              launch, launch_next;
  logic              kind;
  logic [RAW_W-1:0]  raw;
  logic              bad;
  logic [WORD_W-1:0] acc, w, s;
  logic [31:0]       t_res;
  logic [31:0]       p_res;

  logic              mul_start, mul_done;
  logic [WORD_W-1:0] mul_a, mul_b, mul_prod;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_num, div_den, div_quo;

  logic [WORD_W-1:0] raw64, t1, v, pdiff, num, v1d, q13, psum, p_calc;
  logic [31:0]       ft_new, t5;
  logic              neg_n, neg_d;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t  <= '0;
      cal_pl <= '0;
      cal_pm <= '0;
      cal_ph <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP:     cal_t  <= cfg_data;
        CFG_PRESS_LO: cal_pl <= cfg_data;
        CFG_PRESS_MI: cal_pm <= cfg_data;
        CFG_PRESS_HI: cal_ph <= cfg_data;
        default: ;
      endcase
    end
  end

  assign raw64  = {{(WORD_W-RAW_W){1'b0}}, raw};
  assign t1     = {{(WORD_W-16){1'b0}}, cal_t[15:0]};
  assign v      = sx32(fine_t) - WORD_W'(128000);
  assign pdiff  = WORD_W'(1048576) - raw64;
  assign num    = (pdiff << 31) - acc;
  assign v1d    = WORD_W'($signed(mul_prod) >>> 33);
  assign q13    = WORD_W'($signed(s) >>> 13);
  assign psum   = s + acc + WORD_W'($signed(mul_prod) >>> 19);
  assign p_calc = WORD_W'($signed(psum) >>> 8) + (sx16(cal_ph[15:0]) << 4);
  assign ft_new = w[31:0] + 32'($signed(mul_prod[31:0]) >>> 14);
  assign t5     = (ft_new << 2) + ft_new + 32'd128;
  assign neg_n  = acc[WORD_W-1];
  assign neg_d  = w[WORD_W-1];

  assign div_num = neg_n ? (WORD_W'(0) - acc) : acc;
  assign div_den = neg_d ? (WORD_W'(0) - w) : w;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = req_type ? ST_P_1 : ST_T_A;
        end
      end
      ST_T_A: begin
        mul_a = (raw64 >> 3) - (t1 << 1);
        mul_b = sx16(cal_t[31:16]);
        if (mul_done) state_next = ST_T_D;
      end
      ST_T_D: begin
        mul_a = (raw64 >> 4) - t1;
        mul_b = (raw64 >> 4) - t1;
        if (mul_done) state_next = ST_T_E;
      end
      ST_T_E: begin
        mul_a = s;
        mul_b = sx16(cal_t[47:32]);
        if (mul_done) state_next = ST_FIN;
      end
      ST_P_1: begin
        mul_a = v;
        mul_b = v;
        if (mul_done) state_next = ST_P_2;
      end
      ST_P_2: begin
        mul_a = s;
        mul_b = sx16(cal_pm[47:32]);
        if (mul_done) state_next = ST_P_3;
      end
      ST_P_3: begin
        mul_a = v;
        mul_b = sx16(cal_pm[31:16]);
        if (mul_done) state_next = ST_P_4;
      end
      ST_P_4: begin
        mul_a = s;
        mul_b = sx16(cal_pl[47:32]);
        if (mul_done) state_next = ST_P_5;
      end
      ST_P_5: begin
        mul_a = v;
        mul_b = sx16(cal_pl[31:16]);
        if (mul_done) state_next = ST_P_6;
      end
      ST_P_6: begin
        mul_a = (WORD_W'(1) << 47) + w;
        mul_b = {{(WORD_W-16){1'b0}}, cal_pl[15:0]};
        if (mul_done) state_next = (v1d == '0) ? ST_FIN : ST_P_7;
      end
      ST_P_7: begin
        mul_a = num;
        mul_b = WORD_W'(3125);
        if (mul_done) state_next = ST_P_DIV;
      end
      ST_P_DIV: begin
        if (div_done) state_next = ST_P_8;
      end
      ST_P_8: begin
        mul_a = sx16(cal_ph[47:32]);
        mul_b = q13;
        if (mul_done) state_next = ST_P_9;
      end
      ST_P_9: begin
        mul_a = acc;
        mul_b = q13;
        if (mul_done) state_next = ST_P_10;
      end
      ST_P_10: begin
        mul_a = sx16(cal_ph[31:16]);
        mul_b = s;
        if (mul_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    launch_next = (state_next != state) && (state_next != ST_FIN) &&
                  (state_next != ST_IDLE);
  end

  assign mul_start = launch && (state != ST_P_DIV);
  assign div_start = launch && (state == ST_P_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_t <= '0;
    end else if (state == ST_T_E && mul_done) begin
      fine_t <= ft_new;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      kind <= req_type;
      raw  <= raw_sample;
      bad  <= 1'b0;
    end
    if (mul_done) begin
      unique case (state)
        ST_T_A:  w   <= sx32(32'($signed(mul_prod[31:0]) >>> 11));
        ST_T_D:  s   <= sx32(32'($signed(mul_prod[31:0]) >>> 12));
        ST_T_E:  t_res <= 32'($signed(t5) >>> 8);
        ST_P_1:  s   <= mul_prod;
        ST_P_2:  acc <= mul_prod;
        ST_P_3:  acc <= acc + (mul_prod << 17) + (sx16(cal_pm[15:0]) << 35);
        ST_P_4:  w   <= WORD_W'($signed(mul_prod) >>> 8);
        ST_P_5:  w   <= w + (mul_prod << 12);
        ST_P_6: begin
          w   <= v1d;
          bad <= (v1d == '0);
        end
        ST_P_7:  acc <= mul_prod;
        ST_P_8:  acc <= mul_prod;
        ST_P_9:  acc <= WORD_W'($signed(mul_prod) >>> 25);
        ST_P_10: p_res <= p_calc[31:0];
        default: ;
      endcase
    end
    if (state == ST_P_DIV && div_done) begin
      s <= (neg_n != neg_d) ? (WORD_W'(0) - div_quo) : div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!out_valid || out_ready)) begin
      result_kind       <= kind;
      temperature_centi <= kind ? '0 : t_res;
      pressure_q24_8    <= (kind && !bad) ? p_res : '0;
      pressure_invalid  <= kind && bad;
    end
  end

  bptc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  bptc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "took a second item")
  `ASSERT_CLK(a_temp_fields_zero, (out_valid && !result_kind) |-> (pressure_q24_8 == 32'd0 && !pressure_invalid), "temperature result carries pressure data")

endmodule
